/* rtl/core/bounded_lifo_stack_unit_defines.svh */
// Assertion macros for the bounded LIFO stack unit.
`ifndef BOUNDED_LIFO_STACK_UNIT_DEFINES_SVH
`define BOUNDED_LIFO_STACK_UNIT_DEFINES_SVH

// Checked at every rising edge outside reset.
`define BLS_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define BLS_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* rtl/core/bls_pkg.sv */
// Package for the bounded LIFO stack unit: opcodes, status codes and defaults.
package bls_pkg;

   localparam int DEPTH_DEFAULT      = 256;
   localparam int DATA_WIDTH_DEFAULT = 32;
   localparam int CAPACITY_RESET     = 256;

   typedef enum logic [2:0] {
      OP_PUSH  = 3'd0,
      OP_POP   = 3'd1,
      OP_PEEK  = 3'd2,
      OP_READ  = 3'd3,
      OP_CLEAR = 3'd4
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_INDEX = 2'd3
   } status_type;

   // Stage between the RAM access and the output register.
   typedef struct packed {
      status_type status;
      logic       use_mem;
      logic [8:0] size_after;
   } stage_type;

endpackage

/* rtl/core/bls_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module bls_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/bounded_lifo_stack_unit.sv */
// Bounded LIFO stack unit: entry RAM, fill counter, capacity register, result pipeline.
//
//   channel  direction  handshake          words
//   req_     in         valid / stall      opcode, push value, read index
//   rsp_     out        valid / stall      status, data, size after
//   csr_     in         valid / ready      capacity
//
// One word per cycle unless stalled; a result passes the middle and output registers.
// The RAM is read or written at the edge that accepts a request, so the next request
// already sees the new fill count and the written entry.
// Reset clears the fill count and sets the capacity to 256; the RAM is not cleared.
// A stalled result holds the middle stage, which then stalls the request side.
`include "bounded_lifo_stack_unit_defines.svh"

module bounded_lifo_stack_unit #(
   parameter int DEPTH      = bls_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = bls_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_opcode,
   input  logic signed [31:0] req_push_value,
   input  logic [7:0]         req_read_index,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_data,
   output logic [8:0]         rsp_size_after,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [8:0]         csr_capacity
);

   localparam int AddrW = $clog2(DEPTH);
   localparam int CntW  = $clog2(DEPTH + 1);
   localparam int CmpW  = (CntW > 9) ? CntW : 9;
   localparam int WideW = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;

   logic [8:0]            capacity_ff;
   logic [8:0]            capacity_in;
   logic [CntW-1:0]       fill_ff;
   logic [CntW-1:0]       fill_in;
   logic                  s1_valid_ff;
   logic                  s1_valid_in;
   bls_pkg::stage_type    s1_ff;
   bls_pkg::stage_type    s1_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [1:0]            rsp_status_ff;
   logic [1:0]            rsp_status_in;
   logic signed [31:0]    rsp_data_ff;
   logic signed [31:0]    rsp_data_in;
   logic [8:0]            rsp_size_ff;
   logic [8:0]            rsp_size_in;

   logic                  req_accept;
   logic                  s1_advance;
   logic                  s1_held;
   logic                  push_taken;
   logic                  wr_en;
   logic                  rd_en;
   logic [AddrW-1:0]      rd_addr;
   logic [DATA_WIDTH-1:0] wr_data;
   logic [DATA_WIDTH-1:0] rd_data;
   logic [WideW-1:0]      push_wide;
   logic [WideW-1:0]      rd_wide;
   logic [CmpW-1:0]       fill_cmp;
   logic [CmpW-1:0]       cap_cmp;
   logic [CmpW-1:0]       usable_cmp;
   logic [CmpW-1:0]       index_cmp;
   logic [CmpW-1:0]       fill_next_cmp;
   logic                  is_full;
   logic                  is_empty;

   assign csr_ready   = 1'b1;
   assign capacity_in = (csr_valid && csr_ready) ? csr_capacity : capacity_ff;

   assign s1_advance = s1_valid_ff && !(rsp_valid_ff && rsp_stall);
   assign req_stall  = s1_valid_ff && !s1_advance;
   assign req_accept = req_valid && !req_stall;
   assign s1_held    = s1_valid_ff && !s1_advance;
   assign push_taken = req_accept && (req_opcode == bls_pkg::OP_PUSH) && !is_full;

   assign fill_cmp   = CmpW'(fill_ff);
   assign cap_cmp    = CmpW'(capacity_ff);
   assign usable_cmp = (cap_cmp > CmpW'(DEPTH)) ? CmpW'(DEPTH) : cap_cmp;
   assign index_cmp  = CmpW'(req_read_index);
   assign is_full    = fill_cmp >= usable_cmp;
   assign is_empty   = (fill_ff == '0);

   // Pushed words keep their low bits; reads come back zero-extended.
   assign push_wide = WideW'($unsigned(req_push_value));
   assign wr_data   = push_wide[DATA_WIDTH-1:0];
   assign rd_wide   = WideW'(rd_data);

   always_comb begin
      wr_en          = 1'b0;
      rd_en          = 1'b0;
      rd_addr        = '0;
      fill_in        = fill_ff;
      s1_in.status   = bls_pkg::ST_OK;
      s1_in.use_mem  = 1'b0;
      case (req_opcode)
         bls_pkg::OP_PUSH: begin
            if (is_full) begin
               s1_in.status = bls_pkg::ST_FULL;
            end else begin
               wr_en = req_accept;
               if (req_accept) begin
                  fill_in = fill_ff + 1'b1;
               end
            end
         end
         bls_pkg::OP_POP: begin
            if (is_empty) begin
               s1_in.status = bls_pkg::ST_EMPTY;
            end else begin
               rd_en         = req_accept;
               rd_addr       = AddrW'(fill_ff - 1'b1);
               s1_in.use_mem = 1'b1;
               if (req_accept) begin
                  fill_in = fill_ff - 1'b1;
               end
            end
         end
         bls_pkg::OP_PEEK: begin
            if (is_empty) begin
               s1_in.status = bls_pkg::ST_EMPTY;
            end else begin
               rd_en         = req_accept;
               rd_addr       = AddrW'(fill_ff - 1'b1);
               s1_in.use_mem = 1'b1;
            end
         end
         bls_pkg::OP_READ: begin
            if (index_cmp >= fill_cmp) begin
               s1_in.status = bls_pkg::ST_INDEX;
            end else begin
               rd_en         = req_accept;
               rd_addr       = index_cmp[AddrW-1:0];
               s1_in.use_mem = 1'b1;
            end
         end
         bls_pkg::OP_CLEAR: begin
            if (req_accept) begin
               fill_in = '0;
            end
         end
         default: begin
         end
      endcase
      fill_next_cmp    = CmpW'(fill_in);
      s1_in.size_after = fill_next_cmp[8:0];
   end

   assign s1_valid_in  = req_accept || (s1_valid_ff && !s1_advance);
   assign rsp_valid_in = s1_advance || (rsp_valid_ff && rsp_stall);

   always_comb begin
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_size_in   = rsp_size_ff;
      if (s1_advance) begin
         rsp_status_in = s1_ff.status;
         rsp_data_in   = s1_ff.use_mem ? $signed(rd_wide[31:0]) : 32'sd0;
         rsp_size_in   = s1_ff.size_after;
      end
   end

   bls_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (fill_ff[AddrW-1:0]),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= 9'(bls_pkg::CAPACITY_RESET);
         fill_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         capacity_ff  <= capacity_in;
         fill_ff      <= fill_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_ff <= s1_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_size_ff   <= rsp_size_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_data       = rsp_data_ff;
   assign rsp_size_after = rsp_size_ff;

   // The fill count is unknown before the first reset edge.
   `BLS_ASSERT_ALWAYS(a_fill_bound, reset || (fill_cmp <= CmpW'(DEPTH)), "fill count above depth")
   `BLS_ASSERT(a_push_grows, push_taken |=> fill_ff == $past(fill_ff) + 1'b1, "push did not grow")
   `BLS_ASSERT(a_stage_hold, s1_held |=> s1_valid_ff && $stable(s1_ff), "held stage overwritten")
   `BLS_ASSERT(a_push_full_no_write, is_full |-> !wr_en, "write issued on a full stack")

endmodule
